### hw/rtl/hxe_pkg.sv
// ----------------------------------------------------------------------------
// hxe_pkg
// Shared types, constants and character helpers for the hex record encoder.
// ----------------------------------------------------------------------------
package hxe_pkg;

  // Work queue between the parser and the character emitter
  localparam int QDEPTH = 4;

  // Header value of max_record_bytes after reset
  localparam logic [7:0] MAX_REC_RESET = 8'd32;

  // Emitter step index, one step per character of a record
  typedef logic [3:0] step_t;

  // Data record character positions
  localparam step_t STEP_COLON    = 4'd0;
  localparam step_t STEP_CNT_HI   = 4'd1;
  localparam step_t STEP_CNT_LO   = 4'd2;
  localparam step_t STEP_ADR_3    = 4'd3;
  localparam step_t STEP_ADR_2    = 4'd4;
  localparam step_t STEP_ADR_1    = 4'd5;
  localparam step_t STEP_ADR_0    = 4'd6;
  localparam step_t STEP_TYP_HI   = 4'd7;
  localparam step_t STEP_TYP_LO   = 4'd8;
  localparam step_t STEP_DAT_HI   = 4'd9;
  localparam step_t STEP_DAT_LO   = 4'd10;
  localparam step_t STEP_CHK_HI   = 4'd11;
  localparam step_t STEP_CHK_LO   = 4'd12;
  localparam step_t STEP_NEWLINE  = 4'd13;
  localparam step_t STEP_EOF_LAST = 4'd11;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_DATA
  } phase_t;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_EOF,
    JOB_ERR
  } job_kind_t;

  // One entry of work for the emitter
  typedef struct packed {
    job_kind_t   kind;
    logic        rec_start;
    logic        rec_end;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  chk;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
  endfunction

  // ":00000001FF\n"
  function automatic logic [7:0] eof_char(input step_t s);
    case (s)
      STEP_COLON:    eof_char = 8'h3A;
      4'd8:          eof_char = 8'h31;
      4'd9, 4'd10:   eof_char = 8'h46;
      STEP_EOF_LAST: eof_char = 8'h0A;
      default:       eof_char = 8'h30;
    endcase
  endfunction

endpackage

### hw/rtl/hxe_in_if.sv
// ----------------------------------------------------------------------------
// hxe_in_if
// Input channel: stream bytes and end-of-stream marks, valid/ready.
// ----------------------------------------------------------------------------
interface hxe_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] in_byte;

  modport source (output valid, output opcode, output in_byte, input ready);
  modport sink   (input valid, input opcode, input in_byte, output ready);
endinterface

### hw/rtl/hxe_out_if.sv
// ----------------------------------------------------------------------------
// hxe_out_if
// Output channel: one hex text character per beat, valid/ready.
// ----------------------------------------------------------------------------
interface hxe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;
  logic       format_error;

  modport source (output valid, output out_char, output last_of_run,
                  output format_error, input ready);
  modport sink   (input valid, input out_char, input last_of_run,
                  input format_error, output ready);
endinterface

### hw/rtl/hxe_front.sv
// ----------------------------------------------------------------------------
// hxe_front
// Stream parser: walks chunk headers and data, tracks record boundaries and
// checksums, and posts one job per item that produces text.
// ----------------------------------------------------------------------------
module hxe_front
  import hxe_pkg::*;
#(
  parameter int MAX_CHUNK_LEN = 1024
) (
  input  logic        clk,
  input  logic        rst,
  hxe_in_if.sink      in_ch,
  input  logic [7:0]  max_record_bytes,
  input  logic        q_full,
  output logic        push,
  output job_t        job
);

  localparam int CW = (MAX_CHUNK_LEN > 2) ? $clog2(MAX_CHUNK_LEN) : 1;
  localparam logic [16:0] MAX_LEN = 17'(MAX_CHUNK_LEN);

  phase_t          phase, phase_next;
  logic [23:0]     hdr, hdr_next;
  logic [CW-1:0]   crem, crem_next;
  logic [15:0]     raddr, raddr_next;
  logic [7:0]      rrem, rrem_next;
  logic [7:0]      rsum, rsum_next;
  logic            err, err_next;

  logic            accept;
  logic            job_push;
  logic [15:0]     hdr_len;
  logic [15:0]     hdr_addr;
  logic [7:0]      lim;
  logic [7:0]      cnt;
  logic            rec_start;
  logic [7:0]      rrem_eff;
  logic [7:0]      sum_base;
  logic [7:0]      sum_new;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept && job_push;

  assign hdr_len   = hdr[23:8];
  assign hdr_addr  = {hdr[7:0], in_ch.in_byte};
  assign lim       = (max_record_bytes == 8'd0) ? 8'd1 : max_record_bytes;
  assign cnt       = (17'(crem) < 17'(lim)) ? 8'(crem) : lim;
  assign rec_start = (rrem == 8'd0);
  assign rrem_eff  = rec_start ? cnt : rrem;
  assign sum_base  = rec_start ? (cnt + raddr[15:8] + raddr[7:0]) : rsum;
  assign sum_new   = sum_base + in_ch.in_byte;

  // Next phase
  always_comb begin
    phase_next = phase;
    if (in_ch.opcode) begin
      phase_next = PH_HDR0;
    end else if (!err) begin
      case (phase)
        PH_HDR0: phase_next = PH_HDR1;
        PH_HDR1: phase_next = PH_HDR2;
        PH_HDR2: phase_next = PH_HDR3;
        PH_HDR3: begin
          if (hdr_len == 16'd0 || {1'b0, hdr_len} >= MAX_LEN) begin
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          if (crem == CW'(1)) phase_next = PH_HDR0;
        end
        default: phase_next = PH_HDR0;
      endcase
    end
  end

  // Datapath and job
  always_comb begin
    hdr_next   = hdr;
    crem_next  = crem;
    raddr_next = raddr;
    rrem_next  = rrem;
    rsum_next  = rsum;
    err_next   = err;
    job_push   = 1'b0;
    job        = '0;
    job.kind   = JOB_ERR;
    if (in_ch.opcode) begin
      hdr_next  = '0;
      crem_next = '0;
      rrem_next = '0;
      rsum_next = '0;
      if (err) begin
        err_next = 1'b0;
      end else if (phase != PH_HDR0) begin
        job_push = 1'b1;
      end else begin
        job_push = 1'b1;
        job.kind = JOB_EOF;
      end
    end else if (!err) begin
      case (phase)
        PH_HDR0, PH_HDR1, PH_HDR2: begin
          hdr_next = {hdr[15:0], in_ch.in_byte};
        end
        PH_HDR3: begin
          hdr_next = '0;
          if (hdr_len == 16'd0) begin
            // empty chunk: skip silently
          end else if ({1'b0, hdr_len} >= MAX_LEN) begin
            err_next = 1'b1;
            job_push = 1'b1;
          end else begin
            crem_next  = CW'(hdr_len);
            raddr_next = hdr_addr;
            rrem_next  = '0;
            rsum_next  = '0;
          end
        end
        PH_DATA: begin
          job_push      = 1'b1;
          job.kind      = JOB_DATA;
          job.rec_start = rec_start;
          job.rec_end   = (rrem_eff == 8'd1);
          job.count     = cnt;
          job.addr      = raddr;
          job.data      = in_ch.in_byte;
          job.chk       = 8'd0 - sum_new;
          if (rec_start) raddr_next = raddr + {8'd0, cnt};
          rrem_next = rrem_eff - 8'd1;
          rsum_next = (rrem_eff == 8'd1) ? 8'd0 : sum_new;
          crem_next = crem - CW'(1);
          if (crem == CW'(1)) rrem_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
      hdr   <= '0;
      crem  <= '0;
      raddr <= '0;
      rrem  <= '0;
      rsum  <= '0;
      err   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      hdr   <= hdr_next;
      crem  <= crem_next;
      raddr <= raddr_next;
      rrem  <= rrem_next;
      rsum  <= rsum_next;
      err   <= err_next;
    end
  end

endmodule

### hw/rtl/hxe_queue.sv
// ----------------------------------------------------------------------------
// hxe_queue
// Short job queue between parser and emitter.
// ----------------------------------------------------------------------------
module hxe_queue
  import hxe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int PW = $clog2(QDEPTH);

  job_t              mem [QDEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (PW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/hxe_back.sv
// ----------------------------------------------------------------------------
// hxe_back
// Character emitter: steps through the head job one character per beat into
// a registered output stage.
// ----------------------------------------------------------------------------
module hxe_back
  import hxe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  hxe_out_if.source  out_ch
);

  logic        started;
  step_t       step;
  step_t       step_eff;
  step_t       first_step;
  step_t       last_step;
  logic        load;
  logic        at_last;
  logic [7:0]  ch;
  logic        ch_err;

  logic        ovalid;
  logic [7:0]  ochar;
  logic        olast;
  logic        oerr;

  always_comb begin
    case (head.kind)
      JOB_DATA: begin
        first_step = head.rec_start ? STEP_COLON : STEP_DAT_HI;
        last_step  = head.rec_end ? STEP_NEWLINE : STEP_DAT_LO;
      end
      JOB_EOF: begin
        first_step = STEP_COLON;
        last_step  = STEP_EOF_LAST;
      end
      default: begin
        first_step = STEP_COLON;
        last_step  = STEP_COLON;
      end
    endcase
  end

  assign step_eff = started ? step : first_step;
  assign at_last  = (step_eff == last_step);

  always_comb begin
    ch     = 8'h00;
    ch_err = 1'b0;
    case (head.kind)
      JOB_DATA: begin
        case (step_eff)
          STEP_COLON:   ch = 8'h3A;
          STEP_CNT_HI:  ch = hex_char(head.count[7:4]);
          STEP_CNT_LO:  ch = hex_char(head.count[3:0]);
          STEP_ADR_3:   ch = hex_char(head.addr[15:12]);
          STEP_ADR_2:   ch = hex_char(head.addr[11:8]);
          STEP_ADR_1:   ch = hex_char(head.addr[7:4]);
          STEP_ADR_0:   ch = hex_char(head.addr[3:0]);
          STEP_TYP_HI:  ch = 8'h30;
          STEP_TYP_LO:  ch = 8'h30;
          STEP_DAT_HI:  ch = hex_char(head.data[7:4]);
          STEP_DAT_LO:  ch = hex_char(head.data[3:0]);
          STEP_CHK_HI:  ch = hex_char(head.chk[7:4]);
          STEP_CHK_LO:  ch = hex_char(head.chk[3:0]);
          STEP_NEWLINE: ch = 8'h0A;
          default:      ch = 8'h00;
        endcase
      end
      JOB_EOF: ch = eof_char(step_eff);
      default: ch_err = 1'b1;
    endcase
  end

  // Load a new beat when the output stage is free or being drained
  assign load = !empty && (!ovalid || out_ch.ready);
  assign pop  = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      step    <= '0;
      ovalid  <= 1'b0;
    end else begin
      if (load) begin
        ovalid  <= 1'b1;
        started <= !at_last;
        step    <= step_eff + 4'd1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ochar <= ch;
      olast <= at_last;
      oerr  <= ch_err;
    end
  end

  assign out_ch.valid        = ovalid;
  assign out_ch.out_char     = ochar;
  assign out_ch.last_of_run  = olast;
  assign out_ch.format_error = oerr;

endmodule

### hw/rtl/chunk_to_intel_hex_encoder.sv
// ----------------------------------------------------------------------------
// chunk_to_intel_hex_encoder
// Turns a chunked byte stream (length, load address, data) into Intel HEX
// text, one ASCII character per output beat.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+--------------------------------------
//   in_ch    | in  | valid/ready   | opcode[0], in_byte[7:0]
//   out_ch   | out | valid/ready   | out_char[7:0], last_of_run, format_error
//   cfg      | in  | cfg_we        | cfg_data[7:0] -> max_record_bytes
//
// The parser takes one input beat per cycle whenever the 4-entry job queue
// has room; data bytes, headers and ends never wait on the output side until
// that queue fills.
// The emitter produces one character per cycle while out_ch is ready and a job
// is queued: a data byte is 2 characters, plus 9 per record opening and 3 per
// close; EOF is 12, an error 1; 32-byte records give about 2.4 per data byte.
// rst is synchronous: parser state, queue pointers and the output stage clear,
// and max_record_bytes returns to 32.
// Output stalls back up through the queue into in_ch.ready only.
// ----------------------------------------------------------------------------
module chunk_to_intel_hex_encoder
  import hxe_pkg::*;
#(
  parameter int MAX_CHUNK_LEN = 1024
) (
  input  logic       clk,
  input  logic       rst,
  hxe_in_if.sink     in_ch,
  hxe_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  logic [7:0] max_record_bytes;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  job_t       q_in;
  job_t       q_head;

  // Record size register; the user must write it only while idle; not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_bytes <= MAX_REC_RESET;
    end else if (cfg_we) begin
      max_record_bytes <= cfg_data;
    end
  end

  // Front: classify each beat, keep chunk/record state, post jobs
  hxe_front #(
    .MAX_CHUNK_LEN (MAX_CHUNK_LEN)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_ch            (in_ch),
    .max_record_bytes (max_record_bytes),
    .q_full           (q_full),
    .push             (q_push),
    .job              (q_in)
  );

  // Queue: decouple parsing from the slower character stream
  hxe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Back: expand each job into its characters, one beat per cycle while out_ch is ready
  hxe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

### hw/rtl/hxe_checker.sv
// ----------------------------------------------------------------------------
// hxe_checker
// Port-level checks for the hex record encoder, bound to the top level.
// ----------------------------------------------------------------------------
module hxe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_of_run,
  input logic       format_error
);

  // Hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char)
      && $stable(last_of_run) && $stable(format_error))
    else $error("output beat changed while stalled");

  // An error beat is a lone zero character
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_error |-> out_char == 8'h00 && last_of_run)
    else $error("error beat malformed");

  // Newline always closes a run
  a_nl_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == 8'h0A |-> last_of_run && !format_error)
    else $error("newline not last of run");

  // Drop output and open input right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind chunk_to_intel_hex_encoder hxe_checker u_hxe_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_char     (out_ch.out_char),
  .last_of_run  (out_ch.last_of_run),
  .format_error (out_ch.format_error)
);

### verif/hxe_text_checker.sv
// ----------------------------------------------------------------------------
// hxe_text_checker
// Watches the stream and text channels of the hex record encoder, predicts
// every text beat from the accepted stream beats and compares in order.
// ----------------------------------------------------------------------------
module hxe_text_checker
  import hxe_pkg::*;
#(
  parameter int MAX_CHUNK_LEN = 1024
) (
  input  logic       clk,
  input  logic       rst,
  hxe_in_if          in_ch,
  hxe_out_if         out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output int         pending,
  output int         mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } text_beat_t;

  text_beat_t  text_q[$];
  text_beat_t  want;
  int          fail_cnt;

  // Predicted encoder state
  logic [7:0]  max_rec;
  phase_t      ph;
  logic [23:0] hdr;
  logic [15:0] chunk_left;
  logic [15:0] rec_addr;
  logic [7:0]  rec_left;
  logic [7:0]  run_sum;
  logic        err_latched;

  function automatic logic [7:0] nibble_ascii(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'd0, v};
    return 8'h41 + {4'd0, v - 4'd10};
  endfunction

  task automatic push_char(input logic [7:0] ch, input logic err);
    text_q.push_back('{ch: ch, last: 1'b0, err: err});
  endtask

  task automatic push_hex(input logic [7:0] v);
    push_char(nibble_ascii(v[7:4]), 1'b0);
    push_char(nibble_ascii(v[3:0]), 1'b0);
  endtask

  task automatic clear_stream();
    ph         = PH_HDR0;
    hdr        = '0;
    chunk_left = '0;
    rec_left   = '0;
    run_sum    = '0;
  endtask

  task automatic encode_beat(input logic op, input logic [7:0] b);
    int          size_at_entry;
    string       eof_text;
    logic [15:0] len16;
    logic [15:0] addr16;
    logic [7:0]  lim;
    logic [7:0]  cnt;
    size_at_entry = text_q.size();
    eof_text      = ":00000001FF\n";
    if (op) begin
      if (err_latched) begin
        err_latched = 1'b0;
        clear_stream();
      end else if (ph != PH_HDR0) begin
        clear_stream();
        push_char(8'h00, 1'b1);
      end else begin
        for (int i = 0; i < eof_text.len(); i++) push_char(eof_text[i], 1'b0);
      end
    end else if (err_latched) begin
      // drop everything until the end mark
    end else if (ph != PH_HDR3 && ph != PH_DATA) begin
      hdr = {hdr[15:0], b};
      ph  = phase_t'(ph + 3'd1);
    end else if (ph == PH_HDR3) begin
      len16  = hdr[23:8];
      addr16 = {hdr[7:0], b};
      hdr    = '0;
      if (len16 == 16'd0) begin
        ph = PH_HDR0;
      end else if (int'(len16) >= MAX_CHUNK_LEN) begin
        ph          = PH_HDR0;
        err_latched = 1'b1;
        push_char(8'h00, 1'b1);
      end else begin
        chunk_left = len16;
        rec_addr   = addr16;
        rec_left   = '0;
        run_sum    = '0;
        ph         = PH_DATA;
      end
    end else begin
      if (rec_left == 8'd0) begin
        lim = (max_rec == 8'd0) ? 8'd1 : max_rec;
        cnt = (chunk_left < {8'h00, lim}) ? chunk_left[7:0] : lim;
        push_char(":", 1'b0);
        push_hex(cnt);
        push_hex(rec_addr[15:8]);
        push_hex(rec_addr[7:0]);
        push_hex(8'h00);
        run_sum  = cnt + rec_addr[15:8] + rec_addr[7:0];
        rec_left = cnt;
        rec_addr = rec_addr + {8'h00, cnt};
      end
      push_hex(b);
      run_sum    = run_sum + b;
      rec_left   = rec_left - 8'd1;
      chunk_left = chunk_left - 16'd1;
      if (rec_left == 8'd0) begin
        push_hex(8'h00 - run_sum);
        push_char("\n", 1'b0);
        run_sum = '0;
      end
      if (chunk_left == 16'd0) begin
        ph       = PH_HDR0;
        rec_left = '0;
      end
    end
    if (text_q.size() > size_at_entry) text_q[text_q.size() - 1].last = 1'b1;
  endtask

  initial begin
    fail_cnt   = 0;
    pending    = 0;
    mismatches = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      max_rec     = MAX_REC_RESET;
      err_latched = 1'b0;
      rec_addr    = '0;
      clear_stream();
      text_q.delete();
    end else begin
      if (cfg_we) max_rec = cfg_data;
      if (in_ch.valid && in_ch.ready) encode_beat(in_ch.opcode, in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (text_q.size() == 0) begin
          $display("%0t unexpected text beat: char %02h last %0b err %0b", $time,
                   out_ch.out_char, out_ch.last_of_run, out_ch.format_error);
          fail_cnt++;
        end else begin
          want = text_q.pop_front();
          if (out_ch.out_char !== want.ch) begin
            $display("%0t out_char: expected %02h, actual %02h", $time, want.ch,
                     out_ch.out_char);
            fail_cnt++;
          end
          if (out_ch.last_of_run !== want.last) begin
            $display("%0t last_of_run: expected %0b, actual %0b", $time, want.last,
                     out_ch.last_of_run);
            fail_cnt++;
          end
          if (out_ch.format_error !== want.err) begin
            $display("%0t format_error: expected %0b, actual %0b", $time, want.err,
                     out_ch.format_error);
            fail_cnt++;
          end
        end
      end
    end
    pending    <= text_q.size();
    mismatches <= fail_cnt;
  end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the chunk to Intel HEX encoder: directed chunks,
// ends and malformed headers, then random chunk streams under several record
// sizes and idle patterns, checked beat by beat by the text checker.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHUNK    = 1024;
  localparam int CYCLE_LIMIT  = 400000;
  // Parser, 4-deep job queue and emitter: settle margin that covers any tail
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BEATS   = 25;

  // Stream opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;
  int         pending;
  int         mismatches;

  // Stimulus knobs and counters; the stall knobs are shared with the receiver process
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int beats_sent;

  hxe_in_if  in_ch ();
  hxe_out_if out_ch ();

  chunk_to_intel_hex_encoder #(
    .MAX_CHUNK_LEN(MAX_CHUNK)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  hxe_text_checker #(
    .MAX_CHUNK_LEN(MAX_CHUNK)
  ) text_chk (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost text beat ends here
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus asks
  // for one. The hold-off is counted here so the sender keeps running.
  initial begin
    int hold_served;
    int hold_left;
    hold_served  = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one beat and hold it until accepted. Valid is only lowered when an
  // idle gap is inserted, so back-to-back beats keep it high.
  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Beat that the encoder drops while an error is latched; not counted
  task automatic skip_beat(input logic [7:0] b);
    send_beat(OP_BYTE, b);
    beats_sent--;
  endtask

  // End mark; the byte lane carries noise to show it is ignored
  task automatic send_end();
    send_beat(OP_END, 8'($urandom));
  endtask

  // Big-endian length, then big-endian load address
  task automatic send_header(input logic [15:0] len, input logic [15:0] addr);
    send_beat(OP_BYTE, len[15:8]);
    send_beat(OP_BYTE, len[7:0]);
    send_beat(OP_BYTE, addr[15:8]);
    send_beat(OP_BYTE, addr[7:0]);
  endtask

  task automatic send_chunk(input logic [15:0] len, input logic [15:0] addr);
    send_header(len, addr);
    repeat (int'(len)) send_beat(OP_BYTE, 8'($urandom));
  endtask

  // Mostly short chunks; now and then a longer one
  function automatic logic [15:0] chunk_len();
    if ($urandom_range(15) == 0) return 16'($urandom_range(160, 41));
    return 16'($urandom_range(40, 1));
  endfunction

  // A quarter of the chunks start just below the top so records wrap
  function automatic logic [15:0] chunk_addr();
    if ($urandom_range(3) == 0) return 16'hFFFF - 16'($urandom_range(40));
    return 16'($urandom);
  endfunction

  // Drop valid, wait for every predicted beat, then let the pipe go quiet
  task automatic drain_out();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_record(input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random stream: well-formed chunks dominate, the rest are ends, empty
  // chunks, oversize lengths, cut-off headers and cut-off data.
  task automatic random_stream(input int quota);
    int          stop_at;
    int          r;
    int          n;
    logic [15:0] len;
    stop_at = beats_sent + quota;
    while (beats_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 62) begin
        send_chunk(chunk_len(), chunk_addr());
      end else if (r < 70) begin
        send_header(16'd0, chunk_addr());
      end else if (r < 78) begin
        send_end();
      end else if (r < 84) begin
        // oversize length latches an error; trailing bytes vanish
        send_header(16'($urandom_range(65535, MAX_CHUNK)), chunk_addr());
        n = $urandom_range(3);
        repeat (n) skip_beat(8'($urandom));
        send_end();
      end else if (r < 91) begin
        n = $urandom_range(3, 1);
        repeat (n) send_beat(OP_BYTE, 8'($urandom));
        send_end();
      end else begin
        len = chunk_len();
        send_header(len, chunk_addr());
        n = $urandom_range(int'(len) - 1);
        repeat (n) send_beat(OP_BYTE, 8'($urandom));
        send_end();
      end
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_BYTE;
    in_ch.in_byte  = 8'h00;
    cfg_we         = 1'b0;
    cfg_data       = 8'h00;
    rst            = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    beats_sent     = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, with the reset record size of 32
    send_end();                                  // end-of-file on an empty stream
    send_header(16'd2, 16'hFFFF);                // top address, extreme bytes
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_BYTE, 8'h00);
    send_header(16'd0, 16'h1234);                // empty chunk: silent
    send_end();
    send_header(16'd1024, 16'h0000);             // first oversize length
    skip_beat(8'h55);
    send_end();                                  // end while latched: silent
    send_beat(OP_BYTE, 8'h00);                   // end inside a header
    send_end();
    send_header(16'd3, 16'h8000);                // end inside chunk data
    send_beat(OP_BYTE, 8'hA5);
    send_end();
    drain_out();

    // Phase A: record size zero acts as one, no idling; the receiver holds
    // off for a long stretch so the job queue fills and stalls the input
    write_max_record(8'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    send_chunk(16'd40, 16'hFFF0);
    random_stream(PHASE_BEATS);
    drain_out();

    // Phase B: largest records, sender idles; a header of the largest legal
    // length is taken as data, then cut short by an end
    write_max_record(8'd255);
    send_idle_pct  = 52;
    recv_stall_pct = 0;
    send_header(16'(MAX_CHUNK - 1), 16'hFF00);
    repeat (3) send_beat(OP_BYTE, 8'($urandom));
    send_end();
    random_stream(PHASE_BEATS);
    drain_out();

    // Phase C: one byte per record, receiver stalls
    write_max_record(8'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    random_stream(PHASE_BEATS);
    drain_out();

    // Phase D: random small record size, light idling on both sides
    write_max_record(8'($urandom_range(16, 2)));
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    random_stream(PHASE_BEATS);
    send_end();
    drain_out();

    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/hxe_pkg.sv
hw/rtl/hxe_in_if.sv
hw/rtl/hxe_out_if.sv
hw/rtl/hxe_front.sv
hw/rtl/hxe_queue.sv
hw/rtl/hxe_back.sv
hw/rtl/chunk_to_intel_hex_encoder.sv
hw/rtl/hxe_checker.sv
verif/hxe_text_checker.sv
verif/tb_top.sv
